### src/rle_span_to_tmds_lane_words_macros.svh
// Assertion macros shared by the span-to-lane-word modules.
// Expects signals clk and arst_n in the scope of each use.
`ifndef RLE_SPAN_TO_TMDS_LANE_WORDS_MACROS_SVH
`define RLE_SPAN_TO_TMDS_LANE_WORDS_MACROS_SVH
`ifndef SYNTH
`define RSW_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define RSW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define RSW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define RSW_ASSERT(lbl, cond, msg)
`define RSW_ASSERT_IMP(lbl, ante, cons, msg)
`define RSW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/rsw_pkg.sv
// Shared constants, codes and types of the span-to-lane-word block.
// No dependencies.
package rsw_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int PAL_DEPTH   = 256;
	localparam int PAL_AW      = $clog2(PAL_DEPTH);
	localparam int LANES       = 3;
	localparam int LANE_W      = 2;
	localparam int SYM_W       = 10;
	localparam int WORD_W      = 2 * SYM_W;
	localparam int PAL_W       = LANES * WORD_W;
	localparam int PEND_W      = LANES * SYM_W;
	localparam int PIX_W       = 11;
	localparam int WP_W        = 9;
	localparam int REP_W       = PIX_W - 1;
	localparam int COLOR_W     = 8;
	localparam int RUN_W       = 8;
	localparam int KIND_W      = 2;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [PIX_W-1:0] LINE_WIDTH_RESET = PIX_W'(640);
	localparam logic [APB_AW-3:0] REG_LINE_WIDTH  = '0;

	typedef enum logic [KIND_W-1:0] {
		KIND_SPAN = 2'd0,
		KIND_EOL  = 2'd1,
		KIND_PAL  = 2'd2
	} kind_t;

	typedef logic [WORD_W-1:0] word_t;

	// one accepted span or end of line, between the front and the run generator
	typedef struct packed {
		logic              bnd;
		logic              fill;
		logic              flush;
		logic              odd;
		logic              ld;
		logic [REP_W-1:0]  nw;
		logic [WP_W-1:0]   ws;
	} s1_t;

	function automatic logic [PIX_W-1:0] cap_width(input logic [PIX_W-1:0] w);
		cap_width = (w > PIX_W'(MAX_WIDTH)) ? PIX_W'(MAX_WIDTH) : w;
	endfunction

endpackage

### src/rsw_channels.sv
// Handshake channels of the span-to-lane-word block: input items and result runs.
// Depends on rsw_pkg.
interface rsw_in_if;
	logic                        valid;
	logic                        ready;
	logic [rsw_pkg::KIND_W-1:0]  kind;
	logic [rsw_pkg::COLOR_W-1:0] color_index;
	logic [rsw_pkg::RUN_W-1:0]   run_minus_one;
	logic [rsw_pkg::LANE_W-1:0]  lane_select;
	logic [rsw_pkg::WORD_W-1:0]  pair_value;

	modport source(output valid, kind, color_index, run_minus_one, lane_select, pair_value,
		input ready);
	modport sink(input valid, kind, color_index, run_minus_one, lane_select, pair_value,
		output ready);
endinterface

interface rsw_out_if;
	logic                       valid;
	logic                       ready;
	logic [rsw_pkg::WP_W-1:0]   word_start;
	logic [rsw_pkg::WORD_W-1:0] lane0_word;
	logic [rsw_pkg::WORD_W-1:0] lane1_word;
	logic [rsw_pkg::WORD_W-1:0] lane2_word;
	logic [rsw_pkg::REP_W-1:0]  repeat_count;
	logic                       line_done;

	modport source(output valid, word_start, lane0_word, lane1_word, lane2_word,
		repeat_count, line_done, input ready);
	modport sink(input valid, word_start, lane0_word, lane1_word, lane2_word,
		repeat_count, line_done, output ready);
endinterface

### src/rsw_span_ctl.sv
// Input front: line state, span clamping and result planning, palette memory.
// Depends on rsw_pkg, rsw_channels and the macro header.
`include "rle_span_to_tmds_lane_words_macros.svh"

module rsw_span_ctl (
	input  logic                         clk,
	input  logic                         arst_n,
	rsw_in_if.sink                       in_ch,
	input  logic                         rearm,
	input  logic [rsw_pkg::PIX_W-1:0]    cap_w,
	input  logic                         s1_take,
	output logic                         s1_valid,
	output rsw_pkg::s1_t                 s1_info,
	output logic [rsw_pkg::PAL_W-1:0]    pal_rdata
);

	logic [rsw_pkg::PAL_W-1:0] pal_mem [rsw_pkg::PAL_DEPTH];

	logic [rsw_pkg::PIX_W-1:0] pl_q;
	logic [rsw_pkg::WP_W-1:0]  wp_q;
	logic                      pend_q;
	logic                      v_s1;
	rsw_pkg::s1_t              info_s1;
	logic [rsw_pkg::PAL_W-1:0] rdata_q;

	logic                      accept;
	logic                      is_span, is_eol, is_pal;
	logic                      pal_we, load;
	logic [rsw_pkg::PIX_W-1:0] run_req, run, rem, pl_new;
	logic                      bnd, odd, pend_new, fill, flush, ld;
	logic [rsw_pkg::REP_W-1:0] nw;
	logic [rsw_pkg::WP_W-1:0]  wp_new;
	logic [rsw_pkg::PAL_AW-1:0] addr;

	assign in_ch.ready = !v_s1 || s1_take;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		is_span = 1'b0;
		is_eol  = 1'b0;
		is_pal  = 1'b0;
		unique case (rsw_pkg::kind_t'(in_ch.kind))
			rsw_pkg::KIND_SPAN: is_span = 1'b1;
			rsw_pkg::KIND_EOL:  is_eol  = 1'b1;
			rsw_pkg::KIND_PAL:  is_pal  = 1'b1;
			default: ;
		endcase
	end

	// clamp the run to the pixels left; end of line takes them all in colour 0
	assign run_req  = is_eol ? pl_q
		: rsw_pkg::PIX_W'(in_ch.run_minus_one) + rsw_pkg::PIX_W'(1);
	assign run      = (run_req > pl_q) ? pl_q : run_req;
	assign bnd      = pend_q && (run != '0);
	assign rem      = run - rsw_pkg::PIX_W'(bnd);
	assign nw       = rem[rsw_pkg::PIX_W-1:1];
	assign odd      = rem[0];
	assign pend_new = (run != '0) ? odd : pend_q;
	assign pl_new   = pl_q - run;
	assign fill     = (nw != '0);
	assign flush    = is_eol && pend_new;
	assign ld       = is_eol || ((pl_new == '0) && !pend_new);
	assign wp_new   = wp_q + rsw_pkg::WP_W'(bnd) + nw[rsw_pkg::WP_W-1:0];
	assign load     = accept && (is_span || is_eol) && (bnd || fill || flush || odd);
	assign pal_we   = accept && is_pal && (in_ch.lane_select < rsw_pkg::LANE_W'(rsw_pkg::LANES));
	assign addr     = is_eol ? '0 : in_ch.color_index[rsw_pkg::PAL_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q   <= rsw_pkg::cap_width(rsw_pkg::LINE_WIDTH_RESET);
			wp_q   <= '0;
			pend_q <= 1'b0;
			v_s1   <= 1'b0;
		end else begin
			if (rearm || (accept && is_eol)) begin
				pl_q   <= cap_w;
				wp_q   <= '0;
				pend_q <= 1'b0;
			end else if (accept && is_span) begin
				pl_q   <= pl_new;
				wp_q   <= wp_new;
				pend_q <= pend_new;
			end
			if (load) begin
				v_s1 <= 1'b1;
			end else if (s1_take) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			info_s1.bnd   <= bnd;
			info_s1.fill  <= fill;
			info_s1.flush <= flush;
			info_s1.odd   <= odd;
			info_s1.ld    <= ld;
			info_s1.nw    <= nw;
			info_s1.ws    <= wp_q;
		end
	end

	// palette: one lane slice written per item, read on load, data held until next load
	always_ff @(posedge clk) begin
		for (int l = 0; l < rsw_pkg::LANES; l++) begin
			if (pal_we && (in_ch.lane_select == rsw_pkg::LANE_W'(l))) begin
				pal_mem[in_ch.color_index[rsw_pkg::PAL_AW-1:0]][l*rsw_pkg::WORD_W +: rsw_pkg::WORD_W]
					<= in_ch.pair_value;
			end
		end
		if (load) begin
			rdata_q <= pal_mem[addr];
		end
	end

	assign s1_valid  = v_s1;
	assign s1_info   = info_s1;
	assign pal_rdata = rdata_q;

	`RSW_ASSERT(a_pl_cap, pl_q <= rsw_pkg::PIX_W'(rsw_pkg::MAX_WIDTH), "pixels left above cap")
	`RSW_ASSERT_IMP(a_s1_work, v_s1, info_s1.bnd || info_s1.fill || info_s1.flush || info_s1.odd, "empty item held")
	`RSW_ASSERT_NXT(a_eol_rearm, accept && is_eol, (wp_q == '0) && !pend_q, "end of line did not rearm")

endmodule

### src/rsw_run_gen.sv
// Run generator: turns one planned item into up to three result runs, output register.
// Depends on rsw_pkg, rsw_channels and the macro header.
`include "rle_span_to_tmds_lane_words_macros.svh"

module rsw_run_gen (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s1_valid,
	input  rsw_pkg::s1_t              s1_info,
	input  logic [rsw_pkg::PAL_W-1:0] pal_rdata,
	output logic                      s1_take,
	rsw_out_if.source                 out_ch
);

	logic                       gen_v_q, bnd_q, fill_q, flush_q, ld_q;
	logic [rsw_pkg::REP_W-1:0]  nw_q;
	logic [rsw_pkg::WP_W-1:0]   ws_q;
	rsw_pkg::word_t             bnd_word_q [rsw_pkg::LANES];
	rsw_pkg::word_t             fill_word_q [rsw_pkg::LANES];
	logic [rsw_pkg::PEND_W-1:0] flush_low_q;
	logic [rsw_pkg::PEND_W-1:0] pend_low_q;

	logic                       out_v_q;
	rsw_pkg::word_t             out_word_q [rsw_pkg::LANES];
	logic [rsw_pkg::WP_W-1:0]   out_ws_q;
	logic [rsw_pkg::REP_W-1:0]  out_rep_q;
	logic                       out_ld_q;

	logic                       out_free, emit, sel_fill, sel_flush;
	logic                       rem_fill, rem_flush, last, gen_free, s1_has;
	logic [rsw_pkg::REP_W-1:0]  rep;
	rsw_pkg::word_t             cur_word [rsw_pkg::LANES];
	logic [rsw_pkg::PEND_W-1:0] low_new, rd_low;

	assign out_free  = !out_v_q || out_ch.ready;
	assign emit      = gen_v_q && out_free;
	assign sel_fill  = !bnd_q && fill_q;
	assign sel_flush = !bnd_q && !fill_q;
	assign rem_fill  = fill_q && !sel_fill;
	assign rem_flush = flush_q && !sel_flush;
	assign last      = !(rem_fill || rem_flush);
	assign gen_free  = !gen_v_q || (emit && last);
	assign s1_has    = s1_info.bnd || s1_info.fill || s1_info.flush;
	assign s1_take   = s1_valid && (!s1_has || gen_free);
	assign rep       = sel_fill ? nw_q : rsw_pkg::REP_W'(1);

	always_comb begin
		for (int l = 0; l < rsw_pkg::LANES; l++) begin
			rd_low[l*rsw_pkg::SYM_W +: rsw_pkg::SYM_W] =
				pal_rdata[l*rsw_pkg::WORD_W +: rsw_pkg::SYM_W];
			if (bnd_q) begin
				cur_word[l] = bnd_word_q[l];
			end else if (fill_q) begin
				cur_word[l] = fill_word_q[l];
			end else begin
				cur_word[l] = {{rsw_pkg::SYM_W{1'b0}},
					flush_low_q[l*rsw_pkg::SYM_W +: rsw_pkg::SYM_W]};
			end
		end
	end

	assign low_new = s1_info.odd ? rd_low : pend_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_v_q <= 1'b0;
			bnd_q   <= 1'b0;
			fill_q  <= 1'b0;
			flush_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_take && s1_has) begin
				gen_v_q <= 1'b1;
				bnd_q   <= s1_info.bnd;
				fill_q  <= s1_info.fill;
				flush_q <= s1_info.flush;
			end else if (emit) begin
				bnd_q   <= 1'b0;
				fill_q  <= rem_fill;
				flush_q <= rem_flush;
				if (last) begin
					gen_v_q <= 1'b0;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			pend_low_q <= low_new;
		end
		if (s1_take && s1_has) begin
			ld_q        <= s1_info.ld;
			nw_q        <= s1_info.nw;
			ws_q        <= s1_info.ws;
			flush_low_q <= low_new;
			for (int l = 0; l < rsw_pkg::LANES; l++) begin
				fill_word_q[l] <= pal_rdata[l*rsw_pkg::WORD_W +: rsw_pkg::WORD_W];
				bnd_word_q[l]  <= {pal_rdata[l*rsw_pkg::WORD_W + rsw_pkg::SYM_W +: rsw_pkg::SYM_W],
					pend_low_q[l*rsw_pkg::SYM_W +: rsw_pkg::SYM_W]};
			end
		end else if (emit) begin
			ws_q <= ws_q + rep[rsw_pkg::WP_W-1:0];
		end
		if (emit) begin
			out_ws_q  <= ws_q;
			out_rep_q <= rep;
			out_ld_q  <= ld_q && last;
			for (int l = 0; l < rsw_pkg::LANES; l++) begin
				out_word_q[l] <= cur_word[l];
			end
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.word_start   = out_ws_q;
	assign out_ch.lane0_word   = out_word_q[0];
	assign out_ch.lane1_word   = out_word_q[1];
	assign out_ch.lane2_word   = out_word_q[2];
	assign out_ch.repeat_count = out_rep_q;
	assign out_ch.line_done    = out_ld_q;

	`RSW_ASSERT_IMP(a_gen_mask, gen_v_q, bnd_q || fill_q || flush_q, "generator holds no run")
	`RSW_ASSERT_IMP(a_rep_nz, out_v_q, out_rep_q != '0, "zero repeat count")
	`RSW_ASSERT_IMP(a_take_free, s1_take && s1_has, gen_free, "item loaded over busy generator")

endmodule

### src/rle_span_to_tmds_lane_words.sv
// Top level: line width register on the APB port, span front and run generator.
// Depends on rsw_pkg, rsw_channels, rsw_span_ctl and rsw_run_gen.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   kind, color_index, run_minus_one, lane_select, pair_value
//  out_ch    out  valid/ready   word_start, lane0..2_word, repeat_count, line_done
//  apb       in   psel/penable  line_width at byte 0, pready tied high
//
// The accept edge captures the item and its palette read; the generator takes them when
// free and emits one run per cycle into the output register while it can accept a run.
// A span yields two runs at most; an end of line up to three.
// Palette writes, ignored items and spans that only leave a half word skip the generator.
// Input stalls while a held item waits for a generator that has runs left to emit.
// Reset needs no clearing pass; the palette reads as undefined until written.
module rle_span_to_tmds_lane_words (
	input  logic                        clk,
	input  logic                        arst_n,
	rsw_in_if.sink                      in_ch,
	rsw_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsw_pkg::APB_AW-1:0]  paddr,
	input  logic [rsw_pkg::APB_DW-1:0]  pwdata,
	output logic [rsw_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	logic [rsw_pkg::PIX_W-1:0] line_width_q;
	logic                      sel_lw, rearm;
	logic [rsw_pkg::PIX_W-1:0] cap_w;
	logic                      s1_valid, s1_take;
	rsw_pkg::s1_t              s1_info;
	logic [rsw_pkg::PAL_W-1:0] pal_rdata;

	assign pready = 1'b1;
	assign sel_lw = (paddr[rsw_pkg::APB_AW-1:2] == rsw_pkg::REG_LINE_WIDTH);
	assign rearm  = psel && penable && pwrite && pready && sel_lw;
	assign cap_w  = rsw_pkg::cap_width(rearm ? pwdata[rsw_pkg::PIX_W-1:0] : line_width_q);
	assign prdata = sel_lw ? rsw_pkg::APB_DW'(line_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= rsw_pkg::LINE_WIDTH_RESET;
		end else if (rearm) begin
			line_width_q <= pwdata[rsw_pkg::PIX_W-1:0];
		end
	end

	rsw_span_ctl u_span_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.rearm     (rearm),
		.cap_w     (cap_w),
		.s1_take   (s1_take),
		.s1_valid  (s1_valid),
		.s1_info   (s1_info),
		.pal_rdata (pal_rdata)
	);

	rsw_run_gen u_run_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_info   (s1_info),
		.pal_rdata (pal_rdata),
		.s1_take   (s1_take),
		.out_ch    (out_ch)
	);

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for rle_span_to_tmds_lane_words: a directed table, then random span,
// end-of-line, palette and ignored items under three idling mixes and several line widths.
// Depends on rsw_pkg, rsw_channels and the block's RTL.
module tb;
	import rsw_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [LANE_W-1:0] LANE_NONE = 2'd3;
	localparam logic [APB_AW-1:0] LW_ADDR   = {REG_LINE_WIDTH, 2'b00};
	localparam int                SETTLE    = 8;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COLOR_W-1:0] color;
		logic [RUN_W-1:0]   runm1;
		logic [LANE_W-1:0]  lane;
		logic [WORD_W-1:0]  pair;
	} span_item_t;

	typedef struct packed {
		logic [WP_W-1:0]   ws;
		logic [WORD_W-1:0] l0;
		logic [WORD_W-1:0] l1;
		logic [WORD_W-1:0] l2;
		logic [REP_W-1:0]  rep;
		logic              ld;
	} lane_run_t;

	typedef struct {
		span_item_t item;
		bit         typed;
		int         n_typed;
		lane_run_t  want;
	} dir_row_t;

	localparam lane_run_t NO_RUN = '0;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rsw_in_if  in_bus();
	rsw_out_if out_bus();

	rle_span_to_tmds_lane_words dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_bus), .out_ch(out_bus),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [PAL_W-1:0]  pal_model [PAL_DEPTH];
	logic [LANES-1:0]  lanes_set [PAL_DEPTH];
	logic [COLOR_W-1:0] full_colors[$];
	logic [PIX_W-1:0]  m_width;
	logic [PIX_W-1:0]  m_left;
	logic [WP_W-1:0]   m_wptr;
	logic              m_pend;
	logic [PEND_W-1:0] m_pend_syms;

	lane_run_t runs_now[$];
	lane_run_t runs_due[$];
	dir_row_t  dir_rows[$];

	int fails;
	int src_idle;
	int snk_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic string run_text(input lane_run_t r);
		return $sformatf("ws=%0d l0=%05h l1=%05h l2=%05h rep=%0d ld=%0b",
			r.ws, r.l0, r.l1, r.l2, r.rep, r.ld);
	endfunction

	function automatic void note_fail(input string msg);
		fails++;
		if (fails <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function automatic void rearm_line();
		m_left = (m_width > PIX_W'(MAX_WIDTH)) ? PIX_W'(MAX_WIDTH) : m_width;
		m_wptr = '0;
		m_pend = 1'b0;
		m_pend_syms = '0;
	endfunction

	function automatic void add_run(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
		input logic [WORD_W-1:0] w2, input logic [REP_W-1:0] rep);
		lane_run_t r;
		r.ws = m_wptr;
		r.l0 = w0;
		r.l1 = w1;
		r.l2 = w2;
		r.rep = rep;
		r.ld = 1'b0;
		runs_now.push_back(r);
		m_wptr = m_wptr + rep[WP_W-1:0];
	endfunction

	function automatic void mark_line_done();
		lane_run_t r;
		r = runs_now.pop_back();
		r.ld = 1'b1;
		runs_now.push_back(r);
	endfunction

	function automatic void expand_span(input logic [COLOR_W-1:0] color,
		input logic [PIX_W-1:0] run_in);
		logic [PIX_W-1:0]  run;
		logic [PAL_W-1:0]  e;
		logic [WORD_W-1:0] p0;
		logic [WORD_W-1:0] p1;
		logic [WORD_W-1:0] p2;
		run = (run_in > m_left) ? m_left : run_in;
		if (run == 0)
			return;
		m_left = m_left - run;
		e = pal_model[color];
		p0 = e[WORD_W-1:0];
		p1 = e[2*WORD_W-1:WORD_W];
		p2 = e[3*WORD_W-1:2*WORD_W];
		if (m_pend) begin
			add_run({p0[WORD_W-1:SYM_W], m_pend_syms[SYM_W-1:0]},
				{p1[WORD_W-1:SYM_W], m_pend_syms[2*SYM_W-1:SYM_W]},
				{p2[WORD_W-1:SYM_W], m_pend_syms[3*SYM_W-1:2*SYM_W]}, REP_W'(1));
			m_pend = 1'b0;
			m_pend_syms = '0;
			run = run - 1'b1;
			if (run == 0)
				return;
		end
		if (run[PIX_W-1:1] != 0)
			add_run(p0, p1, p2, run[PIX_W-1:1]);
		if (run[0]) begin
			m_pend_syms = {p2[SYM_W-1:0], p1[SYM_W-1:0], p0[SYM_W-1:0]};
			m_pend = 1'b1;
		end
	endfunction

	function automatic void predict_lane_runs(input span_item_t it);
		runs_now.delete();
		case (it.kind)
			KIND_SPAN: begin
				expand_span(it.color, PIX_W'(it.runm1) + 1'b1);
				if (runs_now.size() > 0 && m_left == 0 && !m_pend)
					mark_line_done();
			end
			KIND_EOL: begin
				expand_span('0, m_left);
				if (m_pend)
					add_run({{SYM_W{1'b0}}, m_pend_syms[SYM_W-1:0]},
						{{SYM_W{1'b0}}, m_pend_syms[2*SYM_W-1:SYM_W]},
						{{SYM_W{1'b0}}, m_pend_syms[3*SYM_W-1:2*SYM_W]}, REP_W'(1));
				if (runs_now.size() > 0)
					mark_line_done();
				rearm_line();
			end
			KIND_PAL: begin
				if (it.lane != LANE_NONE) begin
					pal_model[it.color][it.lane*WORD_W +: WORD_W] = it.pair;
					if (lanes_set[it.color] != '1) begin
						lanes_set[it.color][it.lane] = 1'b1;
						if (lanes_set[it.color] == '1)
							full_colors.push_back(it.color);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [COLOR_W-1:0] color,
		input logic [RUN_W-1:0] runm1, input logic [LANE_W-1:0] lane,
		input logic [WORD_W-1:0] pair, input bit typed, input int n_typed, input lane_run_t want);
		dir_row_t row;
		row.item = '{kind, color, runm1, lane, pair};
		row.typed = typed;
		row.n_typed = n_typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	task automatic push_item(input span_item_t it, input bit typed, input int n_typed,
		input lane_run_t want);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			in_bus.valid = 1'b0;
			@(negedge clk);
		end
		in_bus.valid = 1'b1;
		in_bus.kind = it.kind;
		in_bus.color_index = it.color;
		in_bus.run_minus_one = it.runm1;
		in_bus.lane_select = it.lane;
		in_bus.pair_value = it.pair;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		predict_lane_runs(it);
		if (typed) begin
			if (n_typed != 0)
				runs_due.push_back(want);
		end else begin
			foreach (runs_now[i])
				runs_due.push_back(runs_now[i]);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_bus.valid = 1'b0;
		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_line_width(input logic [PIX_W-1:0] w);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = LW_ADDR;
		pwdata = APB_DW'(w);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		m_width = w;
		rearm_line();
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== APB_DW'(w))
			note_fail($sformatf("line_width read %0h, wrote %0h", prdata, w));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	always @(negedge clk) begin
		out_bus.ready = ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin : check_runs
		lane_run_t got;
		lane_run_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			got = '{out_bus.word_start, out_bus.lane0_word, out_bus.lane1_word,
				out_bus.lane2_word, out_bus.repeat_count, out_bus.line_done};
			if (runs_due.size() == 0) begin
				note_fail($sformatf("unexpected run %s", run_text(got)));
			end else begin
				want = runs_due.pop_front();
				if (got.ws !== want.ws || got.l0 !== want.l0 || got.l1 !== want.l1 ||
					got.l2 !== want.l2 || got.rep !== want.rep || got.ld !== want.ld)
					note_fail($sformatf("expected %s, got %s", run_text(want), run_text(got)));
			end
		end
	end

	initial begin
		span_item_t it;
		int r;
		logic [SYM_W-1:0] s;
		logic [PIX_W-1:0] seg_width[9] = '{11'd2047, 11'd1, 11'd96, 11'd0, 11'd1023,
			11'd2, 11'd1024, 11'd333, 11'd640};
		int seg_items[9] = '{30, 20, 28, 8, 34, 20, 34, 28, 28};

		fails = 0;
		src_idle = 10;
		snk_idle = 70;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.kind = KIND_SPAN;
		in_bus.color_index = '0;
		in_bus.run_minus_one = '0;
		in_bus.lane_select = '0;
		in_bus.pair_value = '0;
		out_bus.ready = 1'b0;
		foreach (pal_model[i]) begin
			pal_model[i] = '0;
			lanes_set[i] = '0;
		end
		m_width = LINE_WIDTH_RESET;
		rearm_line();
		seg_width[8] = PIX_W'($urandom_range(700, 3));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(KIND_PAL, 8'd0, 8'd0, 2'd0, 20'h00000, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd0, 8'd0, 2'd1, 20'hFFFFF, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd0, 8'd0, 2'd2, 20'h5A5A5, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd255, 8'd255, 2'd0, 20'hFFFFF, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd255, 8'd0, 2'd1, 20'h00000, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd255, 8'd0, 2'd2, 20'hABCDE, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd1, 8'd0, 2'd0, 20'h12345, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd1, 8'd0, 2'd1, 20'h6789A, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd1, 8'd0, 2'd2, 20'hBCDEF, 1, 0, NO_RUN);
		add_row(KIND_PAL, 8'd7, 8'd0, LANE_NONE, 20'hFFFFF, 1, 0, NO_RUN);
		add_row(KIND_NONE, 8'hAA, 8'h55, 2'd1, 20'hA5A5A, 1, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd255, 8'd255, 2'd0, 20'h0, 1, 1,
			'{9'd0, 20'hFFFFF, 20'h00000, 20'hABCDE, 10'd128, 1'b0});
		add_row(KIND_SPAN, 8'd1, 8'd0, 2'd0, 20'h0, 1, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd0, 8'd2, 2'd0, 20'h0, 0, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd0, 8'd255, 2'd0, 20'h0, 0, 0, NO_RUN);
		add_row(KIND_EOL, 8'd0, 8'd0, 2'd0, 20'h0, 0, 0, NO_RUN);
		add_row(KIND_EOL, 8'hFF, 8'hFF, 2'd3, 20'hFFFFF, 0, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd1, 8'd255, 2'd0, 20'h0, 0, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd1, 8'd255, 2'd0, 20'h0, 0, 0, NO_RUN);
		add_row(KIND_SPAN, 8'd255, 8'd255, 2'd0, 20'h0, 1, 1,
			'{9'd256, 20'hFFFFF, 20'h00000, 20'hABCDE, 10'd64, 1'b1});
		add_row(KIND_SPAN, 8'd1, 8'd0, 2'd0, 20'h0, 1, 0, NO_RUN);
		add_row(KIND_EOL, 8'd0, 8'd0, 2'd0, 20'h0, 1, 0, NO_RUN);

		foreach (dir_rows[i])
			push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].n_typed, dir_rows[i].want);

		for (int seg = 0; seg < 9; seg++) begin
			src_idle = (seg < 3) ? 10 : (seg < 6) ? 70 : 0;
			snk_idle = (seg < 3) ? 70 : (seg < 6) ? 10 : 0;
			wait_drained();
			set_line_width(seg_width[seg]);
			for (int n = 0; n < seg_items[seg]; n++) begin
				if (n == seg_items[seg] / 2)
					wait_drained();
				it.kind = KIND_SPAN;
				it.color = full_colors[$urandom_range(full_colors.size() - 1)];
				it.runm1 = $urandom_range(1) ? RUN_W'($urandom_range(7)) : RUN_W'($urandom_range(255));
				it.lane = LANE_W'($urandom_range(3));
				it.pair = WORD_W'($urandom_range(20'hFFFFF));
				r = $urandom_range(99);
				if (r >= 62 && r < 74) begin
					it.kind = KIND_EOL;
					it.color = COLOR_W'($urandom_range(255));
				end else if (r >= 74 && r < 94) begin
					it.kind = KIND_PAL;
					it.color = ($urandom_range(3) == 0) ? COLOR_W'($urandom_range(255))
						: COLOR_W'($urandom_range(15));
					it.lane = LANE_W'($urandom_range(2));
					s = SYM_W'($urandom_range(10'h3FF));
					if ($urandom_range(1))
						it.pair = {s, s};
				end else if (r >= 94) begin
					it.kind = $urandom_range(1) ? KIND_NONE : KIND_PAL;
					it.lane = $urandom_range(1) ? LANE_NONE : it.lane;
					if (it.kind == KIND_PAL)
						it.lane = LANE_NONE;
					it.color = COLOR_W'($urandom_range(255));
				end
				push_item(it, 0, 0, NO_RUN);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### filelist.f
+incdir+src
src/rsw_pkg.sv
src/rsw_channels.sv
src/rsw_span_ctl.sv
src/rsw_run_gen.sv
src/rle_span_to_tmds_lane_words.sv
verif/tb.sv
